@@ rtl/cpa_pkg.sv @@
`timescale 1ns / 1ps

package cpa_pkg;

   // Field widths
   localparam int PN_W  = 20;
   localparam int CNT_W = 11;

   // Window geometry: used map held as 8-bit words
   localparam int PAGE_COUNT = 1024;
   localparam int OFF_W      = $clog2(PAGE_COUNT);
   localparam int WORD_W     = 8;
   localparam int BIT_W      = $clog2(WORD_W);
   localparam int WORD_COUNT = PAGE_COUNT / WORD_W;
   localparam int WADDR_W    = OFF_W - BIT_W;

   localparam logic [PN_W-1:0] BASE_RESET = PN_W'(128 * 1024);

   // Command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN_RD,
      ST_SCAN,
      ST_MARK_INIT,
      ST_SWEEP_RD,
      ST_SWEEP,
      ST_RESP
   } cpa_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;       // capture the request item
      logic free_init;  // set up a clearing sweep over the whole map
      logic scan_init;  // set up a first-fit scan from word 0
      logic scan_step;  // run one word of the scan
      logic mark_init;  // set up a marking sweep over the found run
      logic addr_inc;   // advance the read address
      logic write;      // write back the modified word
      logic res_load;   // load the result register
   } cpa_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_free;
      logic bad_count;
      logic scan_hit;
      logic data_last;
      logic sweep_last;
   } cpa_status_type;

endpackage

@@ rtl/cpa_req_if.sv @@
`timescale 1ns / 1ps

interface cpa_req_if
   import cpa_pkg::*;
();
   logic             valid;
   logic             ready;
   logic             command;
   logic [CNT_W-1:0] page_count;
   logic [PN_W-1:0]  page_number;

   modport source (output valid, command, page_count, page_number, input ready);
   modport sink   (input valid, command, page_count, page_number, output ready);
endinterface

@@ rtl/cpa_rsp_if.sv @@
`timescale 1ns / 1ps

interface cpa_rsp_if
   import cpa_pkg::*;
();
   logic            valid;
   logic            ready;
   logic            ok;
   logic [PN_W-1:0] first_page;

   modport source (output valid, ok, first_page, input ready);
   modport sink   (input valid, ok, first_page, output ready);
endinterface

@@ rtl/cpa_ctrl.sv @@
`timescale 1ns / 1ps

module cpa_ctrl
   import cpa_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output cpa_cmd_type    cmd,
   input  cpa_status_type status
);

   cpa_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // State and result-valid registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (status.is_free) begin
               cmd.free_init = 1'b1;
               state_in      = ST_SWEEP_RD;
            end else if (status.bad_count) begin
               state_in = ST_RESP;
            end else begin
               cmd.scan_init = 1'b1;
               state_in      = ST_SCAN_RD;
            end
         end
         ST_SCAN_RD: begin
            cmd.addr_inc = 1'b1;
            state_in     = ST_SCAN;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            cmd.addr_inc  = 1'b1;
            if (status.scan_hit) begin
               state_in = ST_MARK_INIT;
            end else if (status.data_last) begin
               state_in = ST_RESP;
            end
         end
         ST_MARK_INIT: begin
            cmd.mark_init = 1'b1;
            state_in      = ST_SWEEP_RD;
         end
         ST_SWEEP_RD: begin
            cmd.addr_inc = 1'b1;
            state_in     = ST_SWEEP;
         end
         ST_SWEEP: begin
            cmd.write    = 1'b1;
            cmd.addr_inc = 1'b1;
            if (status.sweep_last) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            // wait until the result register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.res_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

@@ rtl/cpa_dpath.sv @@
`timescale 1ns / 1ps

module cpa_dpath
   import cpa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_write_enable,
   input  logic [PN_W-1:0]  csr_write_data,
   input  logic             req_command,
   input  logic [CNT_W-1:0] req_page_count,
   input  logic [PN_W-1:0]  req_page_number,
   output logic             rsp_ok,
   output logic [PN_W-1:0]  rsp_first_page,
   input  cpa_cmd_type      cmd,
   output cpa_status_type   status
);

   // Used map, one bit per window page, with a valid flag per word
   logic [WORD_W-1:0]     mem [WORD_COUNT];
   logic [WORD_COUNT-1:0] row_vld_ff;

   logic [PN_W-1:0]    base_ff;
   logic               op_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [PN_W-1:0]    pn_ff;

   logic [WADDR_W-1:0] addr_ff;
   logic [WADDR_W-1:0] data_addr_ff;
   logic [WORD_W-1:0]  rd_data_ff;
   logic               rd_vld_ff;

   logic [CNT_W-1:0]   run_ff;
   logic [OFF_W-1:0]   first_ff;
   logic [OFF_W-1:0]   start_ff;
   logic               found_ff;

   logic [PN_W-1:0]    range_ff;
   logic [WADDR_W-1:0] last_ff;
   logic               set_ff;

   logic               rsp_ok_ff;
   logic [PN_W-1:0]    rsp_page_ff;

   logic [WORD_W-1:0]  word_v;
   logic [CNT_W-1:0]   run_v;
   logic [OFF_W-1:0]   first_v;
   logic [OFF_W-1:0]   start_v;
   logic               hit_v;
   logic [WORD_W-1:0]  wr_word;
   logic [OFF_W:0]     end_off;

   assign word_v = rd_vld_ff ? rd_data_ff : '0;

   // First-fit scan over one word, lowest page first
   always_comb begin
      run_v   = run_ff;
      first_v = first_ff;
      start_v = first_ff;
      hit_v   = 1'b0;
      for (int b = 0; b < WORD_W; b++) begin
         if (!hit_v) begin
            if (!word_v[b]) begin
               if (run_v == '0) begin
                  first_v = {data_addr_ff, BIT_W'(b)};
               end
               run_v = run_v + CNT_W'(1);
               if (run_v >= cnt_ff) begin
                  hit_v   = 1'b1;
                  start_v = first_v;
               end
            end else begin
               run_v = '0;
            end
         end
      end
   end

   // Set or clear the bits of the word that fall in the run
   always_comb begin
      logic [OFF_W-1:0] j_v;
      logic [PN_W-1:0]  d_v;
      wr_word = word_v;
      for (int b = 0; b < WORD_W; b++) begin
         j_v = {data_addr_ff, BIT_W'(b)};
         d_v = PN_W'(j_v) - range_ff;
         if (d_v < PN_W'(cnt_ff)) begin
            wr_word[b] = set_ff;
         end
      end
   end

   // Last offset of the found run
   assign end_off = {1'b0, start_ff} + cnt_ff - (OFF_W + 1)'(1);

   // Map storage with registered read
   always_ff @(posedge clock) begin
      if (cmd.write) begin
         mem[data_addr_ff] <= wr_word;
      end
      rd_data_ff <= mem[addr_ff];
   end

   // Word valid flags and window base
   always_ff @(posedge clock) begin
      if (reset) begin
         row_vld_ff <= '0;
         base_ff    <= BASE_RESET;
      end else begin
         if (cmd.write) begin
            row_vld_ff[data_addr_ff] <= 1'b1;
         end
         if (csr_write_enable) begin
            base_ff <= csr_write_data;
         end
      end
   end

   // Request capture, address counter, scan and sweep registers
   always_ff @(posedge clock) begin
      rd_vld_ff    <= row_vld_ff[addr_ff];
      data_addr_ff <= addr_ff;
      if (cmd.load) begin
         op_ff    <= req_command;
         cnt_ff   <= req_page_count;
         pn_ff    <= req_page_number;
         found_ff <= 1'b0;
      end
      if (cmd.free_init) begin
         addr_ff  <= '0;
         last_ff  <= '1;
         range_ff <= pn_ff - base_ff;
         set_ff   <= 1'b0;
      end else if (cmd.scan_init) begin
         addr_ff  <= '0;
         run_ff   <= '0;
         first_ff <= '0;
      end else if (cmd.mark_init) begin
         addr_ff  <= start_ff[OFF_W-1:BIT_W];
         last_ff  <= end_off[OFF_W-1:BIT_W];
         range_ff <= PN_W'(start_ff);
         set_ff   <= 1'b1;
      end else if (cmd.addr_inc) begin
         addr_ff <= addr_ff + WADDR_W'(1);
      end
      if (cmd.scan_step) begin
         run_ff   <= run_v;
         first_ff <= first_v;
         if (hit_v) begin
            found_ff <= 1'b1;
            start_ff <= start_v;
         end
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (cmd.res_load) begin
         rsp_ok_ff   <= op_ff || found_ff;
         rsp_page_ff <= (op_ff == CMD_ALLOC && found_ff) ? base_ff + PN_W'(start_ff) : '0;
      end
   end

   assign rsp_ok         = rsp_ok_ff;
   assign rsp_first_page = rsp_page_ff;

   assign status.is_free    = (op_ff == CMD_FREE);
   assign status.bad_count  = (cnt_ff == '0) || (cnt_ff > CNT_W'(PAGE_COUNT));
   assign status.scan_hit   = hit_v;
   assign status.data_last  = (data_addr_ff == WADDR_W'(WORD_COUNT - 1));
   assign status.sweep_last = (data_addr_ff == last_ff);

endmodule

@@ rtl/contiguous_page_allocator.sv @@
`timescale 1ns / 1ps

// First-fit contiguous page allocator over a window of 1024 pages starting at
// csr_write_data's page number (reset 131072). An allocate item returns the
// first page of the lowest free run of page_count pages and marks it used, or
// ok = 0 with no change; a free item clears the run's pages inside the window
// and returns ok = 1. One item is worked at a time; the result register lets
// the next item be accepted while a result waits. The used map is a
// 128 x 8-bit memory with one read and one write port, walked one word per
// cycle: allocate scans the words up to the hit and then marks the run's
// words, a failed allocate scans all 128 words, a bad count skips the scan,
// and free makes a pass over all 128 words. The map needs no clearing
// pass after reset: per-word valid flags make unwritten words read as free.
module contiguous_page_allocator
   import cpa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   cpa_req_if.sink         req_chan,
   cpa_rsp_if.source       rsp_chan,
   input  logic            csr_write_enable,
   input  logic [PN_W-1:0] csr_write_data
);

   cpa_cmd_type    cmd;
   cpa_status_type status;

   cpa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd),
      .status    (status)
   );

   cpa_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .req_command      (req_chan.command),
      .req_page_count   (req_chan.page_count),
      .req_page_number  (req_chan.page_number),
      .rsp_ok           (rsp_chan.ok),
      .rsp_first_page   (rsp_chan.first_page),
      .cmd              (cmd),
      .status           (status)
   );

endmodule

@@ rtl/cpa_checker.sv @@
`timescale 1ns / 1ps

module cpa_checker
   import cpa_pkg::*;
(
   input logic            clock,
   input logic            reset,
   input logic            req_valid,
   input logic            req_ready,
   input logic            rsp_valid,
   input logic            rsp_ready,
   input logic            rsp_ok,
   input logic [PN_W-1:0] rsp_first_page
);

   logic [1:0] pend_ff;

   // Items accepted whose result has not yet been taken
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + 2'(req_valid && req_ready) - 2'(rsp_valid && rsp_ready);
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("result with no item outstanding");

   a_two_deep: assert property (@(posedge clock) disable iff (reset)
      pend_ff == 2'd2 |-> !req_ready)
      else $error("item accepted with result and work both pending");

   a_fail_page: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_first_page == '0)
      else $error("failed allocation carries a page number");

endmodule

bind contiguous_page_allocator cpa_checker u_cpa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_ok         (rsp_chan.ok),
   .rsp_first_page (rsp_chan.first_page)
);
